/* rtl/wlt_pkg.sv */
// package for the worker liveness table
// types, sizes and codes shared by the cell and the top level; no dependencies
package wlt_pkg;

  localparam int MAX_ENTRIES          = 64;
  localparam int MAX_CHUNKS_PER_ENTRY = 32;
  localparam int REPORT_CAP           = 64;

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int ETW  = $clog2(MAX_ENTRIES + 1);
  localparam int CW   = $clog2(MAX_CHUNKS_PER_ENTRY + 1);
  localparam int AW   = $clog2(MAX_ENTRIES * MAX_CHUNKS_PER_ENTRY);
  localparam int RIW  = $clog2(REPORT_CAP);
  localparam int RW   = 7;

  localparam logic [1:0] ST_APPROVED     = 2'd0;
  localparam logic [1:0] ST_HEALTHY      = 2'd1;
  localparam logic [1:0] ST_DISCONNECTED = 2'd3;

  localparam logic [2:0] ACT_JOIN      = 3'd0;
  localparam logic [2:0] ACT_HEARTBEAT = 3'd1;
  localparam logic [2:0] ACT_LEAVE     = 3'd2;
  localparam logic [2:0] ACT_TRACK     = 3'd3;
  localparam logic [2:0] ACT_UNTRACK   = 3'd4;
  localparam logic [2:0] ACT_SWEEP     = 3'd5;

  localparam logic [1:0] REG_STALE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAX_REPORTED  = 2'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] worker_key;
    logic [63:0] chunk_ident;
    logic [63:0] now_time;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic        dead_valid;
    logic [63:0] dead_key;
    logic [6:0]  dead_total;
    logic [63:0] version_now;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [63:0]   key;
    logic [1:0]    status;
    logic [63:0]   seen;
    logic [CW-1:0] ctot;
  } entry_t;

endpackage

/* rtl/wlt_cell.sv */
// one table cell: holds one worker entry and hands it to its neighbor
// depends on wlt_pkg for the entry type
module wlt_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  wlt_pkg::entry_t d,
  output wlt_pkg::entry_t q
);

  wlt_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

/* rtl/worker_liveness_table_top.sv */
// worker liveness table top level: ring of entry cells, head-cell sequencer,
// chunk id memory and sweep report memory; depends on wlt_pkg and wlt_cell
//
//  channel | ports                              | role
//  in      | in_valid  in_ready  in_data        | one operation per beat
//  out     | out_valid out_ready out_data       | one or more result beats
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// every operation but those below rotates the ring of MAX_ENTRIES cells once past
// the head cell, then gives one result beat (or one beat per reported key). untrack,
// if the worker is found, then searches its chunk ids and, if it finds the id, shifts
// the later ids down and makes a second ring pass. unused actions and a zero report
// limit skip the pass. reset clears control, entry count and version (to 1); no
// clearing pass. results wait in an output register while out_ready is low.
module worker_liveness_table_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wlt_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wlt_pkg::out_beat_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_US_RD, S_US_CMP, S_SH_RD, S_SH_WR, S_PASS2,
    S_EMIT, S_REP_RD, S_REP_LD, S_REP_OUT
  } state_t;

  state_t state_r;

  wlt_pkg::in_beat_t  op_r;
  wlt_pkg::out_beat_t out_r;
  logic                   out_valid_r;
  logic [63:0]            timeout_r;
  logic [6:0]             max_rep_r;
  logic [63:0]            version_r;
  logic [wlt_pkg::ETW-1:0] total_r;
  logic [wlt_pkg::ETW-1:0] step_r;
  logic                   found_r;
  logic                   ok_r;
  logic [wlt_pkg::IW-1:0] ent_idx_r;
  logic [wlt_pkg::CW-1:0] cnt_r;
  logic [wlt_pkg::CW-1:0] j_r;
  logic [wlt_pkg::RW-1:0] rep_n_r;
  logic [wlt_pkg::RW-1:0] rep_i_r;
  logic [wlt_pkg::RW-1:0] limit_r;

  // chunk store and report store
  logic [63:0] chunk_mem [wlt_pkg::MAX_ENTRIES * wlt_pkg::MAX_CHUNKS_PER_ENTRY];
  logic [63:0] rep_mem [wlt_pkg::REPORT_CAP];
  logic [63:0] chunk_q_r;
  logic [63:0] rep_q_r;

  // ring of cells
  wlt_pkg::entry_t cell_q [wlt_pkg::MAX_ENTRIES];
  wlt_pkg::entry_t head, head_nxt;
  logic            shift_en;

  assign shift_en = (state_r == S_PASS) || (state_r == S_PASS2);

  genvar gi;
  generate
    for (gi = 0; gi < wlt_pkg::MAX_ENTRIES; gi++) begin : g_cell
      if (gi == wlt_pkg::MAX_ENTRIES - 1) begin : g_tail
        wlt_cell u_cell (.clk(clk), .shift_en(shift_en), .d(head_nxt), .q(cell_q[gi]));
      end else begin : g_mid
        wlt_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cell_q[gi+1]), .q(cell_q[gi]));
      end
    end
  endgenerate

  assign head = cell_q[0];

  // head cell processing
  logic                   valid_h, match_h, append_h, stale_h, track_h;
  logic [63:0]            age_h;
  logic [wlt_pkg::AW-1:0] track_addr, us_addr;

  always_comb begin
    valid_h  = step_r < total_r;
    match_h  = valid_h && (head.key == op_r.worker_key);
    append_h = !found_r && (step_r == total_r) &&
               (total_r < wlt_pkg::ETW'(wlt_pkg::MAX_ENTRIES));
    age_h    = op_r.now_time - head.seen;
    stale_h  = valid_h && (head.status != wlt_pkg::ST_DISCONNECTED) &&
               (age_h > timeout_r);
    track_h  = match_h && (head.ctot < wlt_pkg::CW'(wlt_pkg::MAX_CHUNKS_PER_ENTRY));
    head_nxt = head;
    if (state_r == S_PASS2) begin
      if (step_r[wlt_pkg::IW-1:0] == ent_idx_r) head_nxt.ctot = cnt_r - 1'b1;
    end else begin
      case (op_r.action)
        wlt_pkg::ACT_JOIN: begin
          if (match_h) begin
            head_nxt.status = wlt_pkg::ST_APPROVED;
            head_nxt.seen   = op_r.now_time;
          end else if (append_h) begin
            head_nxt.key    = op_r.worker_key;
            head_nxt.status = wlt_pkg::ST_APPROVED;
            head_nxt.seen   = op_r.now_time;
            head_nxt.ctot   = '0;
          end
        end
        wlt_pkg::ACT_HEARTBEAT: begin
          if (match_h) begin
            head_nxt.seen = op_r.now_time;
            if (head.status == wlt_pkg::ST_DISCONNECTED)
              head_nxt.status = wlt_pkg::ST_HEALTHY;
          end
        end
        wlt_pkg::ACT_LEAVE: begin
          if (match_h) head_nxt.status = wlt_pkg::ST_DISCONNECTED;
        end
        wlt_pkg::ACT_TRACK: begin
          if (track_h) head_nxt.ctot = head.ctot + 1'b1;
        end
        wlt_pkg::ACT_SWEEP: begin
          if (stale_h) head_nxt.status = wlt_pkg::ST_DISCONNECTED;
        end
        default: ;
      endcase
    end
    track_addr = wlt_pkg::AW'(step_r[wlt_pkg::IW-1:0]) *
                 wlt_pkg::AW'(wlt_pkg::MAX_CHUNKS_PER_ENTRY) + wlt_pkg::AW'(head.ctot);
    us_addr    = wlt_pkg::AW'(ent_idx_r) *
                 wlt_pkg::AW'(wlt_pkg::MAX_CHUNKS_PER_ENTRY) + wlt_pkg::AW'(j_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_PASS && op_r.action == wlt_pkg::ACT_TRACK && track_h)
      chunk_mem[track_addr] <= op_r.chunk_ident;
    else if (state_r == S_SH_WR)
      chunk_mem[us_addr] <= chunk_q_r;
    if (state_r == S_US_RD)
      chunk_q_r <= chunk_mem[us_addr];
    else if (state_r == S_SH_RD)
      chunk_q_r <= chunk_mem[us_addr + 1'b1];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PASS && op_r.action == wlt_pkg::ACT_SWEEP && stale_h &&
        rep_n_r < limit_r)
      rep_mem[rep_n_r[wlt_pkg::RIW-1:0]] <= head.key;
    if (state_r == S_REP_RD)
      rep_q_r <= rep_mem[rep_i_r[wlt_pkg::RIW-1:0]];
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic pass_last;
  assign pass_last = step_r == wlt_pkg::ETW'(wlt_pkg::MAX_ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      timeout_r   <= 64'd5000;
      max_rep_r   <= 7'd64;
      version_r   <= 64'd1;
      total_r     <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == wlt_pkg::REG_STALE_TIMEOUT) timeout_r <= cfg_data;
        else if (cfg_index == wlt_pkg::REG_MAX_REPORTED) max_rep_r <= cfg_data[6:0];
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r    <= in_data;
            step_r  <= '0;
            found_r <= 1'b0;
            ok_r    <= 1'b0;
            rep_n_r <= '0;
            limit_r <= (max_rep_r > 7'(wlt_pkg::REPORT_CAP)) ?
                       7'(wlt_pkg::REPORT_CAP) : max_rep_r;
            if (in_data.action > wlt_pkg::ACT_SWEEP ||
                (in_data.action == wlt_pkg::ACT_SWEEP && max_rep_r == '0))
              state_r <= S_EMIT;
            else
              state_r <= S_PASS;
          end
        end
        S_PASS: begin
          step_r <= pass_last ? '0 : step_r + 1'b1;
          case (op_r.action)
            wlt_pkg::ACT_JOIN: begin
              if (match_h || append_h) begin
                found_r   <= 1'b1;
                ok_r      <= 1'b1;
                version_r <= version_r + 1'b1;
              end
              if (!match_h && append_h) total_r <= total_r + 1'b1;
            end
            wlt_pkg::ACT_HEARTBEAT, wlt_pkg::ACT_LEAVE: begin
              if (match_h) begin
                ok_r      <= 1'b1;
                version_r <= version_r + 1'b1;
              end
            end
            wlt_pkg::ACT_TRACK: begin
              if (track_h) begin
                ok_r      <= 1'b1;
                version_r <= version_r + 1'b1;
              end
            end
            wlt_pkg::ACT_UNTRACK: begin
              if (match_h) begin
                found_r   <= 1'b1;
                ent_idx_r <= step_r[wlt_pkg::IW-1:0];
                cnt_r     <= head.ctot;
              end
            end
            wlt_pkg::ACT_SWEEP: begin
              if (stale_h) begin
                version_r <= version_r + 1'b1;
                if (rep_n_r < limit_r) rep_n_r <= rep_n_r + 1'b1;
              end
            end
            default: ;
          endcase
          if (pass_last) begin
            j_r    <= '0;
            if (op_r.action == wlt_pkg::ACT_UNTRACK) begin
              state_r <= (found_r || match_h) ? S_US_RD : S_EMIT;
            end else if (op_r.action == wlt_pkg::ACT_SWEEP) begin
              ok_r    <= 1'b1;
              rep_i_r <= '0;
              state_r <= (rep_n_r != '0 || (stale_h && limit_r != '0)) ?
                         S_REP_RD : S_EMIT;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_US_RD: begin
          state_r <= (j_r == cnt_r) ? S_EMIT : S_US_CMP;
        end
        S_US_CMP: begin
          if (chunk_q_r == op_r.chunk_ident) begin
            state_r <= S_SH_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_US_RD;
          end
        end
        S_SH_RD: begin
          // slide later ids down one slot
          if (wlt_pkg::ETW'(j_r) + 1'b1 >= wlt_pkg::ETW'(cnt_r)) state_r <= S_PASS2;
          else state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_SH_RD;
        end
        S_PASS2: begin
          step_r <= step_r + 1'b1;
          if (pass_last) begin
            ok_r      <= 1'b1;
            version_r <= version_r + 1'b1;
            state_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r       <= 1'b1;
            out_r.ok          <= ok_r && !(op_r.action == wlt_pkg::ACT_SWEEP &&
                                           limit_r == '0);
            out_r.dead_valid  <= 1'b0;
            out_r.dead_key    <= '0;
            out_r.dead_total  <= '0;
            out_r.version_now <= version_r;
            out_r.last_of_run <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_REP_RD: begin
          state_r <= S_REP_LD;
        end
        S_REP_LD: begin
          if (!out_valid_r) begin
            out_valid_r       <= 1'b1;
            out_r.ok          <= 1'b1;
            out_r.dead_valid  <= 1'b1;
            out_r.dead_key    <= rep_q_r;
            out_r.dead_total  <= rep_n_r;
            out_r.version_now <= version_r;
            out_r.last_of_run <= (rep_i_r + 1'b1) == rep_n_r;
            rep_i_r           <= rep_i_r + 1'b1;
            state_r           <= S_REP_OUT;
          end
        end
        S_REP_OUT: begin
          state_r <= (rep_i_r == rep_n_r) ? S_IDLE : S_REP_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // entry count never exceeds the table
  assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= wlt_pkg::ETW'(wlt_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  // ring only turns while an operation is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !shift_en || state_r == S_PASS)
    else $error("ring turned outside a pass");

  // a new operation is never taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> !(in_valid && in_ready))
    else $error("operation accepted with result pending");

  // reported count stays within the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PASS |-> rep_n_r <= limit_r)
    else $error("report count above limit");

endmodule

/* test/tb_worker_liveness_table_top.sv */
// testbench for worker_liveness_table_top: directed and random table operations
// checked beat by beat against an in-bench model of the table; needs wlt_pkg,
// wlt_cell and the rtl of the top level
module tb_worker_liveness_table_top;

  localparam int IDLE_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  wlt_pkg::in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  wlt_pkg::out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  worker_liveness_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // table mirror
  logic [63:0] tbl_key [wlt_pkg::MAX_ENTRIES];
  logic [1:0]  tbl_status [wlt_pkg::MAX_ENTRIES];
  logic [63:0] tbl_seen [wlt_pkg::MAX_ENTRIES];
  logic [63:0] tbl_chunk [wlt_pkg::MAX_ENTRIES][wlt_pkg::MAX_CHUNKS_PER_ENTRY];
  int          tbl_ctot [wlt_pkg::MAX_ENTRIES];
  int          tbl_used = 0;
  logic [63:0] version = 64'd1;
  logic [63:0] stale_ms = 64'd5000;
  logic [6:0]  report_limit = 7'd64;

  wlt_pkg::in_beat_t  op_q [$];
  wlt_pkg::out_beat_t result_q [$];
  logic [63:0] key_pool [$];
  logic [63:0] chunk_pool [$];
  logic [63:0] clock_ms = 64'd1000;
  int          mismatches = 0;

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic wlt_pkg::out_beat_t mk_beat(logic ok, logic dv, logic [63:0] dk,
                                                 logic [6:0] cnt, logic last);
    wlt_pkg::out_beat_t r;
    r.ok = ok; r.dead_valid = dv; r.dead_key = dk; r.dead_total = cnt;
    r.version_now = version; r.last_of_run = last;
    return r;
  endfunction

  // apply one operation to the mirror and queue the beats it should produce
  task automatic run_op(wlt_pkg::in_beat_t b);
    int e;
    int lim;
    logic ok;
    logic [63:0] dead [$];
    ok = 1'b0;
    if (b.action == wlt_pkg::ACT_SWEEP) begin
      if (report_limit == 0) begin
        result_q.push_back(mk_beat(1'b0, 1'b0, '0, '0, 1'b1));
        return;
      end
      lim = (report_limit > wlt_pkg::REPORT_CAP) ? wlt_pkg::REPORT_CAP : report_limit;
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_status[i] != wlt_pkg::ST_DISCONNECTED &&
            (b.now_time - tbl_seen[i]) > stale_ms) begin
          tbl_status[i] = wlt_pkg::ST_DISCONNECTED;
          if (dead.size() < lim) dead.push_back(tbl_key[i]);
          version++;
        end
      end
      if (dead.size() == 0)
        result_q.push_back(mk_beat(1'b1, 1'b0, '0, '0, 1'b1));
      for (int i = 0; i < dead.size(); i++)
        result_q.push_back(mk_beat(1'b1, 1'b1, dead[i], 7'(dead.size()),
                                   i + 1 == dead.size()));
      return;
    end
    e = lookup(b.worker_key);
    case (b.action)
      wlt_pkg::ACT_JOIN: begin
        if (e < 0 && tbl_used < wlt_pkg::MAX_ENTRIES) begin
          e = tbl_used++;
          tbl_key[e] = b.worker_key;
          tbl_ctot[e] = 0;
        end
        if (e >= 0) begin
          tbl_status[e] = wlt_pkg::ST_APPROVED;
          tbl_seen[e] = b.now_time;
          version++;
          ok = 1'b1;
        end
      end
      wlt_pkg::ACT_HEARTBEAT: if (e >= 0) begin
        tbl_seen[e] = b.now_time;
        if (tbl_status[e] == wlt_pkg::ST_DISCONNECTED) tbl_status[e] = wlt_pkg::ST_HEALTHY;
        version++;
        ok = 1'b1;
      end
      wlt_pkg::ACT_LEAVE: if (e >= 0) begin
        tbl_status[e] = wlt_pkg::ST_DISCONNECTED;
        version++;
        ok = 1'b1;
      end
      wlt_pkg::ACT_TRACK: if (e >= 0 && tbl_ctot[e] < wlt_pkg::MAX_CHUNKS_PER_ENTRY) begin
        tbl_chunk[e][tbl_ctot[e]] = b.chunk_ident;
        tbl_ctot[e]++;
        version++;
        ok = 1'b1;
      end
      wlt_pkg::ACT_UNTRACK: if (e >= 0) begin
        for (int j = 0; j < tbl_ctot[e]; j++) begin
          if (tbl_chunk[e][j] == b.chunk_ident) begin
            for (int m = j; m + 1 < tbl_ctot[e]; m++)
              tbl_chunk[e][m] = tbl_chunk[e][m + 1];
            tbl_ctot[e]--;
            version++;
            ok = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    result_q.push_back(mk_beat(ok, 1'b0, '0, '0, 1'b1));
  endtask

  // driver: bursts of beats separated by random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) run_op(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || op_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data <= op_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // receiver: stall style is picked at random from four modes
  int stall_mode = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle % 8 != 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    wlt_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = result_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (exp/got): ok %b/%b dead_valid %b/%b dead_key %h/%h",
                     want.ok, out_data.ok, want.dead_valid, out_data.dead_valid,
                     want.dead_key, out_data.dead_key);
            $display("  dead_total %0d/%0d version %0d/%0d last %b/%b",
                     want.dead_total, out_data.dead_total,
                     want.version_now, out_data.version_now,
                     want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_op(logic [2:0] act, logic [63:0] k, logic [63:0] c, logic [63:0] t);
    wlt_pkg::in_beat_t b;
    b.action = act; b.worker_key = k; b.chunk_ident = c; b.now_time = t;
    op_q.push_back(b);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (op_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wlt_pkg::REG_STALE_TIMEOUT) stale_ms = val;
    else if (idx == wlt_pkg::REG_MAX_REPORTED) report_limit = val[6:0];
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return rand64();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic random_ops(int count);
    int r;
    logic [2:0] act;
    logic [63:0] k;
    logic [63:0] c;
    logic [63:0] t;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      act = (r < 20) ? wlt_pkg::ACT_JOIN : (r < 40) ? wlt_pkg::ACT_HEARTBEAT :
            (r < 48) ? wlt_pkg::ACT_LEAVE : (r < 68) ? wlt_pkg::ACT_TRACK :
            (r < 85) ? wlt_pkg::ACT_UNTRACK : (r < 95) ? wlt_pkg::ACT_SWEEP :
            3'($urandom_range(6, 7));
      k = pick_key();
      if (act == wlt_pkg::ACT_JOIN && key_pool.size() < 80) key_pool.push_back(k);
      c = ($urandom_range(0, 9) == 0) ? rand64()
                                       : chunk_pool[$urandom_range(0, chunk_pool.size() - 1)];
      clock_ms += $urandom_range(0, 80);
      t = ($urandom_range(0, 19) == 0) ? rand64() : clock_ms;
      push_op(act, k, c, t);
    end
  endtask

  initial begin
    logic [63:0] k0;
    chunk_pool = '{64'd0, '1, 64'd7, 64'h8000_0000_0000_0001, 64'd42, 64'h5555_aaaa_5555_aaaa};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of every field, every action, revive, duplicates, wrap
    push_op(wlt_pkg::ACT_JOIN, 64'd0, 64'd0, 64'd0);
    push_op(wlt_pkg::ACT_JOIN, '1, '1, '1 - 64'd10);
    push_op(wlt_pkg::ACT_HEARTBEAT, 64'd99, '0, 64'd5);
    push_op(wlt_pkg::ACT_TRACK, 64'd0, 64'd0, 64'd1);
    push_op(wlt_pkg::ACT_TRACK, 64'd0, '1, 64'd1);
    push_op(wlt_pkg::ACT_TRACK, 64'd0, 64'd0, 64'd1);
    push_op(wlt_pkg::ACT_UNTRACK, 64'd0, 64'd0, 64'd2);
    push_op(wlt_pkg::ACT_UNTRACK, 64'd0, 64'd1234, 64'd2);
    push_op(wlt_pkg::ACT_UNTRACK, 64'd0, '1, 64'd2);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, 64'd5);
    push_op(wlt_pkg::ACT_LEAVE, '1, '0, 64'd3);
    push_op(wlt_pkg::ACT_HEARTBEAT, '1, '0, 64'd4);
    push_op(wlt_pkg::ACT_JOIN, 64'd0, '0, 64'd4999);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, 64'd9999);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, 64'd10000);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, 64'd20000);
    push_op(3'd6, 64'd0, '0, '0);
    push_op(3'd7, '1, '1, '1);
    push_op(wlt_pkg::ACT_TRACK, 64'd77, 64'd1, 64'd0);
    push_op(wlt_pkg::ACT_LEAVE, 64'd77, 64'd1, 64'd0);
    push_op(wlt_pkg::ACT_UNTRACK, 64'd77, 64'd1, 64'd0);
    push_op(wlt_pkg::ACT_HEARTBEAT, 64'd0, '0, 64'd30000);
    key_pool.push_back(64'd0);
    key_pool.push_back('1);
    drain();

    write_reg(wlt_pkg::REG_STALE_TIMEOUT, 64'd100);
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd3);
    write_reg(2'd3, '1);
    random_ops(40);
    drain();

    // fill the table past its size, and one chunk list past its size
    write_reg(wlt_pkg::REG_STALE_TIMEOUT, 64'd0);
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd1);
    for (int i = 0; i < 66; i++) begin
      clock_ms += 3;
      k0 = rand64();
      push_op(wlt_pkg::ACT_JOIN, k0, rand64(), clock_ms);
    end
    k0 = key_pool[0];
    for (int i = 0; i < 34; i++)
      push_op(wlt_pkg::ACT_TRACK, k0, chunk_pool[i % 6], clock_ms);
    push_op(wlt_pkg::ACT_UNTRACK, k0, chunk_pool[0], clock_ms);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, clock_ms + 5);
    drain();

    write_reg(wlt_pkg::REG_STALE_TIMEOUT, '1);
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd127);
    random_ops(30);
    drain();
    write_reg(wlt_pkg::REG_STALE_TIMEOUT, 64'd0);
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd127);
    random_ops(15);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, clock_ms + 1000);
    drain();
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd0);
    push_op(wlt_pkg::ACT_SWEEP, '0, '0, clock_ms + 2000);
    random_ops(10);
    drain();
    write_reg(wlt_pkg::REG_STALE_TIMEOUT, 64'd5000);
    write_reg(wlt_pkg::REG_MAX_REPORTED, 64'd64);
    random_ops(10);
    drain();

    repeat (400) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
